// ===== sv/tpc_pkg.sv =====
// Shared types and constants for the thresholded Pearson correlation block.
// No dependencies; imported by tpc_dp, tpc_ctrl, the top level and the testbench.
package tpc_pkg;

	localparam int MAX_PAIRS_DEF = 8192;
	localparam int KEPT_W = 14;
	localparam int CORR_W = 16;
	localparam int Q_W = 15;
	localparam logic signed [7:0] THRESH_RST = 8'sd20;
	localparam logic [Q_W-1:0] Q_SCALE = 15'd32767;
	// 4 * 32767^2, scale applied to C^2 for the root search
	localparam logic [31:0] RHS_K = 32'd4294705156;

	// datapath multiply steps
	typedef enum logic [3:0] {
		OP_A    = 4'd0,
		OP_NSYY = 4'd1,
		OP_SYSY = 4'd2,
		OP_NSXY = 4'd3,
		OP_SXSY = 4'd4,
		OP_AB   = 4'd5,
		OP_CC   = 4'd6,
		OP_RHS  = 4'd7,
		OP_ODD  = 4'd8,
		OP_TEST = 4'd9
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic degen;
		logic search_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== sv/tpc_if.sv =====
// Valid/ready channel interfaces for input pairs and result words.
// Depends on nothing.
interface tpc_in_if;
	logic              valid;
	logic              ready;
	logic              access_flag;
	logic signed [7:0] sample;
	logic              last;
	modport source(output valid, access_flag, sample, last, input ready);
	modport sink(input valid, access_flag, sample, last, output ready);
endinterface

interface tpc_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] correlation;
	logic [13:0]        kept_count;
	logic               degenerate;
	logic               overflowed;
	modport source(output valid, correlation, kept_count, degenerate, overflowed, input ready);
	modport sink(input valid, correlation, kept_count, degenerate, overflowed, output ready);
endinterface

// ===== sv/tpc_mul.sv =====
// Shift-add serial multiplier, one multiplier bit per cycle, early exit.
// Depends on nothing.
module tpc_mul #(
	parameter int XW = 8,
	parameter int YW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] x,
	input  logic [YW-1:0] y,
	output logic          done,
	output logic [XW-1:0] prod
);
	logic          busy_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [XW-1:0] acc_q;

	assign done = busy_q && (y_q == '0);
	assign prod = acc_q;

	// busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// partial product accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q && y_q != '0) begin
			if (y_q[0]) begin
				acc_q <= acc_q + x_q;
			end
			x_q <= x_q << 1;
			y_q <= y_q >> 1;
		end
	end
endmodule

// ===== sv/tpc_dp.sv =====
// Datapath: threshold register, set accumulators, shared multiplier, root
// search registers and the output word register. Uses tpc_pkg and tpc_mul.
module tpc_dp import tpc_pkg::*; #(
	parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [7:0]               wr_data,
	input  logic                     acc_en,
	input  logic                     access_flag,
	input  logic signed [7:0]        sample,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic signed [CORR_W-1:0] correlation,
	output logic [KEPT_W-1:0]        kept_count,
	output logic                     degenerate,
	output logic                     overflowed
);
	localparam int CW  = $clog2(MAX_PAIRS + 1);
	localparam int AW  = 2 * CW;
	localparam int BW  = 2 * CW + 14;
	localparam int CSW = 2 * CW + 9;
	localparam int MW  = 4 * CW + 48;
	localparam int YW  = (2 * CW + 8 > 32) ? 2 * CW + 8 : 32;

	// config and accumulators
	logic signed [7:0]     thr_q;
	logic [CW-1:0]         arr_q, n_q, sx_q;
	logic signed [CW+7:0]  sy_q, sxy_q;
	logic [CW+13:0]        syy_q;
	logic                  ovf_q;
	// final computation
	logic [AW-1:0]         a_q;
	logic [BW-1:0]         b_q;
	logic signed [CSW-1:0] c_q;
	logic [MW-1:0]         ab_q, rhs_q;
	logic [31:0]           tmp_q;
	logic [Q_W-1:0]        lo_q, hi_q;
	// output word
	logic                  ov_q, deg_q, ovfo_q;
	logic signed [CORR_W-1:0] corr_q;
	logic [KEPT_W-1:0]     kept_q;

	logic signed [15:0]    sq;
	logic                  keep;
	logic [CW+7:0]         sy_mag, sxy_mag;
	logic [CSW-1:0]        c_mag;
	logic [Q_W:0]          mid, odd;
	logic [MW-1:0]         mx, mul_p;
	logic [YW-1:0]         my;
	logic                  mul_done;
	logic signed [CSW-1:0] p_c;
	logic                  degen;

	assign sq      = sample * sample;
	assign keep    = sample >= thr_q;
	assign sy_mag  = sy_q[CW+7] ? (CW+8)'(-sy_q) : (CW+8)'(sy_q);
	assign sxy_mag = sxy_q[CW+7] ? (CW+8)'(-sxy_q) : (CW+8)'(sxy_q);
	assign c_mag   = c_q[CSW-1] ? CSW'(-c_q) : CSW'(c_q);
	assign mid     = ({1'b0, lo_q} + {1'b0, hi_q} + 16'd1) >> 1;
	assign odd     = {mid[Q_W-1:0], 1'b0} - 16'd1;
	assign p_c     = $signed(mul_p[CSW-1:0]);
	assign degen   = (a_q == '0) || (b_q == '0);

	assign stat.mul_done    = mul_done;
	assign stat.degen       = degen;
	assign stat.search_done = lo_q >= hi_q;
	assign stat.out_free    = !ov_q || out_ready;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RST;
		end else if (wr_en) begin
			thr_q <= wr_data;
		end
	end

	// per-set accumulators, cleared once the result is handed off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arr_q <= '0; n_q <= '0; sx_q <= '0; sy_q <= '0;
			syy_q <= '0; sxy_q <= '0; ovf_q <= 1'b0;
		end else if (cmd.emit) begin
			arr_q <= '0; n_q <= '0; sx_q <= '0; sy_q <= '0;
			syy_q <= '0; sxy_q <= '0; ovf_q <= 1'b0;
		end else if (acc_en) begin
			if (arr_q >= CW'(MAX_PAIRS)) begin
				ovf_q <= 1'b1;
			end else begin
				arr_q <= arr_q + 1'b1;
				if (keep) begin
					n_q   <= n_q + 1'b1;
					sx_q  <= sx_q + CW'(access_flag);
					sy_q  <= sy_q + (CW+8)'(sample);
					syy_q <= syy_q + (CW+14)'(unsigned'(sq));
					if (access_flag) begin
						sxy_q <= sxy_q + (CW+8)'(sample);
					end
				end
			end
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mx = '0;
		my = '0;
		case (cmd.op)
			OP_A: begin
				mx = MW'(sx_q);
				my = YW'(n_q - sx_q);
			end
			OP_NSYY: begin
				mx = MW'(syy_q);
				my = YW'(n_q);
			end
			OP_SYSY: begin
				mx = MW'(sy_mag);
				my = YW'(sy_mag);
			end
			OP_NSXY: begin
				mx = MW'(sxy_mag);
				my = YW'(n_q);
			end
			OP_SXSY: begin
				mx = MW'(sy_mag);
				my = YW'(sx_q);
			end
			OP_AB: begin
				mx = MW'(b_q);
				my = YW'(a_q);
			end
			OP_CC: begin
				mx = MW'(c_mag);
				my = YW'(c_mag);
			end
			OP_RHS: begin
				mx = rhs_q;
				my = YW'(RHS_K);
			end
			OP_ODD: begin
				mx = MW'(odd);
				my = YW'(odd);
			end
			OP_TEST: begin
				mx = ab_q;
				my = YW'(tmp_q);
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
	end

	tpc_mul #(.XW(MW), .YW(YW)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.x     (mx),
		.y     (my),
		.done  (mul_done),
		.prod  (mul_p)
	);

	// product write-back and bisection on the rounded root
	always_ff @(posedge clk) begin
		if (cmd.start && cmd.op == OP_A) begin
			lo_q <= '0;
			hi_q <= Q_SCALE;
		end
		if (mul_done) begin
			case (cmd.op)
				OP_A:    a_q   <= mul_p[AW-1:0];
				OP_NSYY: b_q   <= mul_p[BW-1:0];
				OP_SYSY: b_q   <= b_q - mul_p[BW-1:0];
				OP_NSXY: c_q   <= sxy_q[CW+7] ? -p_c : p_c;
				OP_SXSY: c_q   <= sy_q[CW+7] ? c_q + p_c : c_q - p_c;
				OP_AB:   ab_q  <= mul_p;
				OP_CC:   rhs_q <= mul_p;
				OP_RHS:  rhs_q <= mul_p;
				OP_ODD:  tmp_q <= mul_p[31:0];
				OP_TEST: begin
					if (mul_p <= rhs_q) begin
						lo_q <= mid[Q_W-1:0];
					end else begin
						hi_q <= mid[Q_W-1:0] - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (degen) begin
				corr_q <= '0;
			end else if (c_q[CSW-1]) begin
				corr_q <= CORR_W'(17'd0 - {2'b00, lo_q});
			end else begin
				corr_q <= CORR_W'(lo_q);
			end
			kept_q <= KEPT_W'(n_q);
			deg_q  <= degen;
			ovfo_q <= ovf_q;
		end
	end

	assign out_valid   = ov_q;
	assign correlation = corr_q;
	assign kept_count  = kept_q;
	assign degenerate  = deg_q;
	assign overflowed  = ovfo_q;
endmodule

// ===== sv/tpc_ctrl.sv =====
// Controller: sequences the multiply steps and the bisection after the last
// word of a set, then hands the result to the output register. Uses tpc_pkg.
module tpc_ctrl import tpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ISSUE = 5'b00010,
		S_WAIT  = 5'b00100,
		S_SRCH  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	op_t    op_q, op_d;

	assign in_ready  = state_q == S_IDLE;
	assign cmd.start = state_q == S_ISSUE;
	assign cmd.op    = op_q;
	assign cmd.emit  = (state_q == S_OUT) && stat.out_free;

	// next state and step
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_last) begin
					op_d    = OP_A;
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: state_d = S_WAIT;
			S_WAIT: begin
				if (stat.mul_done) begin
					state_d = S_ISSUE;
					case (op_q)
						OP_A:    op_d = OP_NSYY;
						OP_NSYY: op_d = OP_SYSY;
						OP_SYSY: op_d = OP_NSXY;
						OP_NSXY: op_d = OP_SXSY;
						OP_SXSY: begin
							// B is final once SYSY is written back
							if (stat.degen) begin
								state_d = S_OUT;
							end else begin
								op_d = OP_AB;
							end
						end
						OP_AB:   op_d = OP_CC;
						OP_CC:   op_d = OP_RHS;
						OP_RHS:  state_d = S_SRCH;
						OP_ODD:  op_d = OP_TEST;
						OP_TEST: state_d = S_SRCH;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SRCH: begin
				if (stat.search_done) begin
					state_d = S_OUT;
				end else begin
					op_d    = OP_ODD;
					state_d = S_ISSUE;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_A;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end
endmodule

// ===== sv/thresholded_pearson_correlation.sv =====
// Top level: thresholded Pearson correlation over flag/sample pairs.
// Uses tpc_pkg, tpc_if, tpc_ctrl and tpc_dp.
//
//  port     | dir | kind        | word
//  ---------+-----+-------------+-------------------------------------------
//  samples  | in  | valid/ready | access_flag, sample, last
//  results  | out | valid/ready | correlation, kept_count, degenerate, overflowed
//  wr_en    | in  | write       | wr_data = sample_threshold
//
// A word without last is accumulated when taken; words stream back to back.
// A word with last starts the final pass: eight serial multiplies, each running
// until its second operand has shifted to zero, then fifteen bisection rounds
// of two multiplies; a zero variance ends the pass before the AB multiply.
// samples.ready is low during the pass and while its result waits for the
// output register to empty. Reset is asynchronous and clears the accumulators
// and the threshold to 20.
module thresholded_pearson_correlation import tpc_pkg::*; #(
	parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [7:0] wr_data,
	tpc_in_if.sink     samples,
	tpc_out_if.source  results
);
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     acc_en;

	assign acc_en = samples.valid && samples.ready;

	tpc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(samples.valid),
		.in_last (samples.last),
		.in_ready(samples.ready),
		.cmd     (cmd),
		.stat    (stat)
	);

	tpc_dp #(.MAX_PAIRS(MAX_PAIRS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_data    (wr_data),
		.acc_en     (acc_en),
		.access_flag(samples.access_flag),
		.sample     (samples.sample),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (results.ready),
		.out_valid  (results.valid),
		.correlation(results.correlation),
		.kept_count (results.kept_count),
		.degenerate (results.degenerate),
		.overflowed (results.overflowed)
	);
endmodule

// ===== sv/tpc_checker.sv =====
// Port-level checks for the correlation block, bound to the top level.
// Depends on thresholded_pearson_correlation.
module tpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] correlation,
	input logic        degenerate
);
	// a held result word stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// coefficient never reaches the most negative code
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> correlation != 16'h8000)
		else $error("correlation out of range");

	// degenerate sets report zero
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> correlation == 16'h0000)
		else $error("degenerate set with nonzero correlation");

	// input closes only after a last word is taken
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_last))
		else $error("input stalled without a last word");
endmodule

bind thresholded_pearson_correlation tpc_checker u_tpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.in_last    (samples.last),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.correlation(results.correlation),
	.degenerate (results.degenerate)
);

// ===== test/thresholded_pearson_correlation_tb.sv =====
// Self-checking testbench for thresholded_pearson_correlation: directed table
// and random sets over several thresholds; uses tpc_pkg, tpc_if.
module thresholded_pearson_correlation_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tpc_pkg::*;

	localparam int RAND_ITEMS = 1900;
	localparam int LONG_HOLD = 4000;
	localparam int SETTLE = 40;

	typedef struct {
		logic signed [15:0] corr;
		logic [13:0]        kept;
		logic               degen;
		logic               ovf;
	} corr_result_t;

	typedef struct {
		logic              flag;
		logic signed [7:0] sample;
		logic              last;
		bit                typed;
		corr_result_t      res;
	} pair_row_t;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       wr_en = 0;
	logic [7:0] wr_data = '0;

	tpc_in_if  samples_if();
	tpc_out_if results_if();

	thresholded_pearson_correlation i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.samples (samples_if),
		.results (results_if)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// predictor state
	logic signed [7:0] cur_thresh = THRESH_RST;
	longint            kept_n, flag_sum, arrivals;
	longint            samp_sum, sq_sum, prod_sum;
	bit                ovf_seen;
	corr_result_t      corr_expected[$];
	int                mismatches = 0;
	int                results_seen = 0;
	bit                stim_done = 0;
	int                burst_left = 0;

	function automatic void clear_set();
		kept_n = 0; flag_sum = 0; arrivals = 0;
		samp_sum = 0; sq_sum = 0; prod_sum = 0; ovf_seen = 0;
	endfunction

	// exact rounded r * 32767 by bisection on the squared inequality
	function automatic corr_result_t finish_set();
		corr_result_t r;
		longint a, b, c;
		logic [127:0] ab, cmag, rhs, odd;
		int lo, hi, mid;
		a = kept_n * flag_sum - flag_sum * flag_sum;
		b = kept_n * sq_sum - samp_sum * samp_sum;
		c = kept_n * prod_sum - flag_sum * samp_sum;
		r.kept = kept_n[13:0];
		r.ovf = ovf_seen;
		r.degen = (a <= 0) || (b <= 0);
		r.corr = 0;
		if (!r.degen) begin
			ab = 128'(a) * 128'(b);
			cmag = (c < 0) ? 128'(-c) : 128'(c);
			rhs = cmag * cmag * (128'(4) * 128'(Q_SCALE) * 128'(Q_SCALE));
			lo = 0;
			hi = int'(Q_SCALE);
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				odd = 128'(2 * mid - 1);
				if (ab * odd * odd <= rhs) lo = mid;
				else hi = mid - 1;
			end
			r.corr = (c < 0) ? -16'(lo) : 16'(lo);
		end
		return r;
	endfunction

	function automatic bit accept_pair(logic flag, logic signed [7:0] s, logic last,
			output corr_result_t r);
		if (arrivals >= MAX_PAIRS_DEF) begin
			ovf_seen = 1;
		end else begin
			arrivals++;
			if (s >= cur_thresh) begin
				kept_n++;
				flag_sum += flag;
				samp_sum += s;
				sq_sum += longint'(s) * longint'(s);
				if (flag) prod_sum += s;
			end
		end
		if (!last) return 0;
		r = finish_set();
		clear_set();
		return 1;
	endfunction

	// send one word with burst/gap pacing; predict on acceptance
	task automatic send_pair(logic flag, logic signed [7:0] s, logic last,
			bit typed = 0, corr_result_t typed_res = '{0, 0, 0, 0});
		corr_result_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				samples_if.valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		samples_if.valid <= 1;
		samples_if.access_flag <= flag;
		samples_if.sample <= s;
		samples_if.last <= last;
		do @(posedge clk); while (!samples_if.ready);
		if (accept_pair(flag, s, last, r))
			corr_expected.push_back(typed ? typed_res : r);
	endtask

	task automatic write_thresh(logic signed [7:0] v);
		samples_if.valid <= 0;
		while (corr_expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		wr_en <= 1;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 0;
		cur_thresh = v;
	endtask

	function automatic logic signed [7:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return -8'sd128;
			1: return 8'sd127;
			2: return 8'(cur_thresh + $urandom_range(0, 2) - 1);
			default: return 8'($urandom);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		corr_result_t e;
		if (results_if.valid && results_if.ready) begin
			results_seen++;
			if (corr_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word corr=%0d",
					results_if.correlation);
			end else begin
				e = corr_expected.pop_front();
				if (results_if.correlation !== e.corr || results_if.kept_count !== e.kept ||
					results_if.degenerate !== e.degen || results_if.overflowed !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp corr=%0d kept=%0d dg=%0b ov=%0b, got %0d %0d %0b %0b",
							e.corr, e.kept, e.degen, e.ovf, results_if.correlation,
							results_if.kept_count, results_if.degenerate, results_if.overflowed);
				end
			end
		end
	end

	// receiver: alternating free and stalling stretches, one long hold-off
	initial begin
		int stretch;
		bit stall_mode, held;
		results_if.ready = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			stretch = $urandom_range(20, 300);
			stall_mode = 1'($urandom_range(0, 1));
			repeat (stretch) begin
				@(posedge clk);
				if (!held && results_seen >= 3) begin
					held = 1;
					results_if.ready <= 0;
					repeat (LONG_HOLD) @(posedge clk);
				end
				results_if.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
			end
		end
	end

	// stimulus
	pair_row_t dir_rows[] = '{
		'{0, 8'sd5,    1, 1, '{0, 0, 1, 0}},
		'{1, 8'sd127,  0, 0, '{0, 0, 0, 0}},
		'{0, -8'sd128, 0, 0, '{0, 0, 0, 0}},
		'{0, 8'sd20,   1, 1, '{16'sd32767, 2, 0, 0}},
		'{0, 8'sd127,  0, 0, '{0, 0, 0, 0}},
		'{1, 8'sd20,   1, 1, '{-16'sd32767, 2, 0, 0}},
		'{1, 8'sd50,   0, 0, '{0, 0, 0, 0}},
		'{1, 8'sd60,   1, 1, '{0, 2, 1, 0}},
		'{0, 8'sd30,   0, 0, '{0, 0, 0, 0}},
		'{1, 8'sd30,   1, 1, '{0, 2, 1, 0}},
		'{1, 8'sd19,   0, 0, '{0, 0, 0, 0}},
		'{1, 8'sd21,   0, 0, '{0, 0, 0, 0}},
		'{0, 8'sd90,   0, 0, '{0, 0, 0, 0}},
		'{1, 8'sd33,   0, 0, '{0, 0, 0, 0}},
		'{0, 8'sd25,   1, 0, '{0, 0, 0, 0}},
		'{1, 8'sd100,  1, 1, '{0, 1, 1, 0}}
	};
	logic signed [7:0] thresh_plan[] = '{-8'sd128, 8'sd127, 8'sd0, -8'sd1,
		8'sd60, -8'sd70, 8'sd20};

	initial begin
		int sent, len, per_phase;
		samples_if.valid = 0;
		samples_if.access_flag = 0;
		samples_if.sample = '0;
		samples_if.last = 0;
		clear_set();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_pair(dir_rows[i].flag, dir_rows[i].sample, dir_rows[i].last,
				dir_rows[i].typed, dir_rows[i].res);

		// random sets, mostly short, under each threshold in turn
		per_phase = RAND_ITEMS / thresh_plan.size();
		foreach (thresh_plan[p]) begin
			write_thresh(thresh_plan[p]);
			sent = 0;
			while (sent < per_phase) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 25);
				for (int k = 0; k < len; k++) begin
					send_pair(1'($urandom_range(0, 1)), rand_sample(), k == len - 1);
					sent++;
				end
			end
		end

		samples_if.valid <= 0;
		stim_done = 1;
	end

	// end of run
	initial begin
		wait (stim_done);
		while (corr_expected.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (mismatches == 0 && corr_expected.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/tpc_pkg.sv
sv/tpc_if.sv
sv/tpc_mul.sv
sv/tpc_dp.sv
sv/tpc_ctrl.sv
sv/thresholded_pearson_correlation.sv
sv/tpc_checker.sv
test/thresholded_pearson_correlation_tb.sv
